// ===== rtl/signed_range_min_max_query_assert.svh =====
// assertion macros for the checker file
`ifndef SIGNED_RANGE_MIN_MAX_QUERY_ASSERT_SVH
`define SIGNED_RANGE_MIN_MAX_QUERY_ASSERT_SVH

// same-cycle implication
`define SRMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srmq assertion failed");

// next-cycle implication
`define SRMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srmq assertion failed");

`endif

// ===== rtl/srmq_pkg.sv =====
// shared types and constants of the signed range min/max query block
`default_nettype none
package srmq_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int TABLE_LEVELS_DEF = 11;

    localparam logic [30:0] FULL_SCALE   = 31'h7FFF_FFFF;
    localparam logic [31:0] ABSENT_MAX   = 32'hFFFF_FFFF;
    localparam logic [10:0] LENGTH_RESET = 11'd1024;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q1,
        S_Q2,
        S_BLV,
        S_BRB,
        S_BWR,
        S_PINIT,
        S_PRD,
        S_PWR
    } t_state;

    typedef struct packed {
        logic        [30:0] pmin;
        logic signed [31:0] pmax;
        logic        [30:0] nmin;
        logic signed [31:0] nmax;
    } t_entry;

    typedef struct packed {
        logic        [30:0] positive_min;
        logic signed [31:0] positive_max;
        logic        [30:0] negative_min_magnitude;
        logic signed [31:0] negative_max_magnitude;
        logic        [10:0] nonnegative_count;
        logic        [10:0] nonpositive_count;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/srmq_ifs.sv =====
// handshake channel interfaces: input item, result, configuration
`default_nettype none
interface srmq_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic        [10:0] position;
    logic signed [31:0] value;
    logic        [10:0] first;
    logic        [10:0] last;
    modport source(output valid, kind, position, value, first, last, input ready);
    modport sink(input valid, kind, position, value, first, last, output ready);
endinterface

interface srmq_result_if;
    logic               valid;
    logic               ready;
    logic        [30:0] positive_min;
    logic signed [31:0] positive_max;
    logic        [30:0] negative_min_magnitude;
    logic signed [31:0] negative_max_magnitude;
    logic        [10:0] nonnegative_count;
    logic        [10:0] nonpositive_count;
    modport source(output valid, positive_min, positive_max, negative_min_magnitude,
                   negative_max_magnitude, nonnegative_count, nonpositive_count,
                   input ready);
    modport sink(input valid, positive_min, positive_max, negative_min_magnitude,
                 negative_max_magnitude, nonnegative_count, nonpositive_count,
                 output ready);
endinterface

interface srmq_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] array_length;
    modport source(output valid, array_length, input ready);
    modport sink(input valid, array_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/srmq_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module srmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output      logic [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/signed_range_min_max_query.sv =====
// top level of the signed range min/max query block
// Loads a signed array one word at a time, builds sparse min/max tables and
// prefix counts on a build word, and answers inclusive range queries. A load
// writes both rams in the cycle it is accepted. A query runs through S_Q1 and
// S_Q2: the table ram and the prefix ram each have one read port and a query
// needs two reads from each, then S_Q2 forms the result into the output
// register; a second result register lets the next item in while a result
// waits. A build walks level by level through the table ram, reading two
// halves and writing one per table entry with a level check between levels,
// then reads and writes each prefix entry; the input stays closed until the
// build is done. The rams are not cleared after reset; every entry a query
// reads must first be written by loads and a build.
`default_nettype none
module signed_range_min_max_query
    import srmq_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TABLE_LEVELS = TABLE_LEVELS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srmq_item_if.sink     i_item,
    srmq_cfg_if.sink      i_cfg,
    srmq_result_if.source o_result
);
    localparam int PW    = $clog2(MAX_ELEMENTS + 1);
    localparam int IW    = $clog2(MAX_ELEMENTS + 2);
    localparam int DEPTH = TABLE_LEVELS * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(TABLE_LEVELS + 1);
    localparam int EW    = $bits(t_entry);

    function automatic logic [AW-1:0] f_slot(input int lv, input int pos);
        return AW'(lv * MAX_ELEMENTS + pos - 1);
    endfunction

    t_state r_state, n_state;
    logic [10:0] r_len;

    // query registers
    logic [AW-1:0]   r_b_addr;
    logic [PW-1:0]   r_lo_m1;
    logic            r_empty;
    t_entry          r_a;
    logic [2*PW-1:0] r_phi;

    // build registers
    logic [LW-1:0] r_lv;
    logic [PW-1:0] r_j;
    logic [IW-1:0] r_i;
    logic [PW-1:0] r_snn, r_snp;

    // output stage
    t_result r_out, r_hold, w_res;
    logic    r_out_valid, r_hold_valid;

    // ram ports
    logic            w_t_we, w_p_we;
    logic [AW-1:0]   w_t_waddr, w_t_raddr;
    t_entry          w_t_wdata, w_t_rdata;
    logic [EW-1:0]   w_t_rbits;
    logic [PW-1:0]   w_p_waddr, w_p_raddr;
    logic [2*PW-1:0] w_p_wdata, w_p_rdata;

    logic          w_acc, w_out_free;
    logic [PW-1:0] w_n;
    logic          w_lv_ok, w_j_ok, w_i_done, w_pos_ok;
    logic [AW-1:0] w_qa, w_qb;
    logic [PW-1:0] w_qhi, w_qlo_m1;
    logic          w_qempty;
    t_entry        w_load_entry, w_b;
    logic [PW-1:0] w_load_nn, w_load_np, w_snn, w_snp;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE) && !r_hold_valid;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_t_rdata    = t_entry'(w_t_rbits);
    assign w_b          = w_t_rdata;

    // clamped length
    always_comb begin
        int len_i;
        len_i = int'(r_len);
        if (len_i < 1) len_i = 1;
        if (len_i > MAX_ELEMENTS) len_i = MAX_ELEMENTS;
        w_n = PW'(len_i);
    end

    assign w_lv_ok  = (int'(r_lv) < TABLE_LEVELS) && ((1 << r_lv) <= int'(w_n));
    assign w_j_ok   = (int'(r_j) + (1 << r_lv) - 1) <= int'(w_n);
    assign w_i_done = int'(r_i) > int'(w_n);
    assign w_pos_ok = (i_item.position != 11'd0) && (int'(i_item.position) <= MAX_ELEMENTS);

    // query window and addresses
    always_comb begin
        int lo_i, hi_i, len_i, u_i;
        logic [PW-1:0] len_v;
        lo_i = (i_item.first == 11'd0) ? 1 : int'(i_item.first);
        hi_i = (int'(i_item.last) > int'(w_n)) ? int'(w_n) : int'(i_item.last);
        len_i = hi_i - lo_i + 1;
        len_v = PW'(len_i);
        u_i = 0;
        for (int k = 0; k < PW; k++) begin
            if (len_v[k]) u_i = k;
        end
        if (u_i > TABLE_LEVELS - 1) u_i = TABLE_LEVELS - 1;
        w_qempty = lo_i > hi_i;
        w_qa     = f_slot(u_i, lo_i);
        w_qb     = f_slot(u_i, hi_i - (1 << u_i) + 1);
        w_qhi    = PW'(hi_i);
        w_qlo_m1 = PW'(lo_i - 1);
    end

    // level-0 entry and class marks for a load
    always_comb begin
        logic [31:0] neg;
        neg = 32'd0 - 32'(i_item.value);
        if (i_item.value == 32'sd0) begin
            w_load_entry = '{pmin: 31'd0, pmax: 32'sd0, nmin: 31'd0, nmax: 32'sd0};
            w_load_nn = PW'(1);
            w_load_np = PW'(1);
        end else if (!i_item.value[31]) begin
            w_load_entry = '{pmin: i_item.value[30:0], pmax: i_item.value,
                             nmin: FULL_SCALE, nmax: ABSENT_MAX};
            w_load_nn = PW'(1);
            w_load_np = '0;
        end else begin
            // most negative word saturates its magnitude
            w_load_entry.pmin = FULL_SCALE;
            w_load_entry.pmax = ABSENT_MAX;
            w_load_entry.nmin = neg[31] ? FULL_SCALE : neg[30:0];
            w_load_entry.nmax = neg[31] ? {1'b0, FULL_SCALE} : {1'b0, neg[30:0]};
            w_load_nn = '0;
            w_load_np = PW'(1);
        end
    end

    assign w_snn = r_snn + w_p_rdata[2*PW-1:PW];
    assign w_snp = r_snp + w_p_rdata[PW-1:0];

    // query result from the two windows and two prefix reads
    always_comb begin
        logic [PW-1:0] cnn, cnp;
        logic [31:0]   cnn32, cnp32;
        cnn   = r_phi[2*PW-1:PW] - w_p_rdata[2*PW-1:PW];
        cnp   = r_phi[PW-1:0] - w_p_rdata[PW-1:0];
        cnn32 = 32'(cnn);
        cnp32 = 32'(cnp);
        if (r_empty) begin
            w_res.positive_min           = FULL_SCALE;
            w_res.positive_max           = ABSENT_MAX;
            w_res.negative_min_magnitude = FULL_SCALE;
            w_res.negative_max_magnitude = ABSENT_MAX;
            w_res.nonnegative_count      = 11'd0;
            w_res.nonpositive_count      = 11'd0;
        end else begin
            w_res.positive_min = (r_a.pmin < w_b.pmin) ? r_a.pmin : w_b.pmin;
            w_res.positive_max = (r_a.pmax > w_b.pmax) ? r_a.pmax : w_b.pmax;
            w_res.negative_min_magnitude = (r_a.nmin < w_b.nmin) ? r_a.nmin : w_b.nmin;
            w_res.negative_max_magnitude = (r_a.nmax > w_b.nmax) ? r_a.nmax : w_b.nmax;
            w_res.nonnegative_count = cnn32[10:0];
            w_res.nonpositive_count = cnp32[10:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_item.kind)
                        KIND_BUILD: n_state = S_BLV;
                        KIND_QUERY: n_state = S_Q1;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_Q1:    n_state = S_Q2;
            S_Q2:    n_state = S_IDLE;
            S_BLV: begin
                if (!w_lv_ok) n_state = S_PINIT;
                else if (w_j_ok) n_state = S_BRB;
            end
            S_BRB:   n_state = S_BWR;
            S_BWR:   n_state = S_BLV;
            S_PINIT: n_state = S_PRD;
            S_PRD:   n_state = w_i_done ? S_IDLE : S_PWR;
            S_PWR:   n_state = S_PRD;
            default: n_state = S_IDLE;
        endcase
    end

    // ram controls
    always_comb begin
        w_t_we    = 1'b0;
        w_t_waddr = f_slot(int'(r_lv), int'(r_j));
        w_t_wdata = w_load_entry;
        w_t_raddr = w_qa;
        w_p_we    = 1'b0;
        w_p_waddr = r_i[PW-1:0];
        w_p_wdata = {w_snn, w_snp};
        w_p_raddr = w_qhi;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_item.kind == KIND_LOAD && w_pos_ok) begin
                    w_t_we    = 1'b1;
                    w_t_waddr = f_slot(0, int'(i_item.position));
                    w_p_we    = 1'b1;
                    w_p_waddr = PW'(i_item.position);
                    w_p_wdata = {w_load_nn, w_load_np};
                end
            end
            S_Q1: begin
                w_t_raddr = r_b_addr;
                w_p_raddr = r_lo_m1;
            end
            S_BLV: w_t_raddr = f_slot(int'(r_lv) - 1, int'(r_j));
            S_BRB: w_t_raddr = f_slot(int'(r_lv) - 1, int'(r_j) + (1 << (r_lv - LW'(1))));
            S_BWR: begin
                w_t_we = 1'b1;
                w_t_wdata.pmin = (r_a.pmin < w_b.pmin) ? r_a.pmin : w_b.pmin;
                w_t_wdata.pmax = (r_a.pmax > w_b.pmax) ? r_a.pmax : w_b.pmax;
                w_t_wdata.nmin = (r_a.nmin < w_b.nmin) ? r_a.nmin : w_b.nmin;
                w_t_wdata.nmax = (r_a.nmax > w_b.nmax) ? r_a.nmax : w_b.nmax;
            end
            S_PINIT: begin
                w_p_we    = 1'b1;
                w_p_waddr = '0;
                w_p_wdata = '0;
            end
            S_PRD: w_p_raddr = r_i[PW-1:0];
            S_PWR: w_p_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= LENGTH_RESET;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_len <= i_cfg.array_length;
            end
            if (w_out_free) begin
                if (r_hold_valid) begin
                    r_out_valid  <= 1'b1;
                    r_hold_valid <= 1'b0;
                end else begin
                    r_out_valid <= (r_state == S_Q2);
                end
            end else if (r_state == S_Q2) begin
                r_hold_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_hold_valid ? r_hold : w_res;
        end else if (r_state == S_Q2) begin
            r_hold <= w_res;
        end
        case (r_state)
            S_IDLE: begin
                r_lv     <= LW'(1);
                r_j      <= PW'(1);
                r_b_addr <= w_qb;
                r_lo_m1  <= w_qlo_m1;
                r_empty  <= w_qempty;
            end
            S_Q1: begin
                r_a   <= w_t_rdata;
                r_phi <= w_p_rdata;
            end
            S_BLV: begin
                if (w_lv_ok && !w_j_ok) begin
                    r_lv <= r_lv + LW'(1);
                    r_j  <= PW'(1);
                end
            end
            S_BRB: r_a <= w_t_rdata;
            S_BWR: r_j <= r_j + PW'(1);
            S_PINIT: begin
                r_i   <= IW'(1);
                r_snn <= '0;
                r_snp <= '0;
            end
            S_PWR: begin
                r_snn <= w_snn;
                r_snp <= w_snp;
                r_i   <= r_i + IW'(1);
            end
            default: ;
        endcase
    end

    srmq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (w_t_waddr),
        .i_wdata (EW'(w_t_wdata)),
        .i_raddr (w_t_raddr),
        .o_rdata (w_t_rbits)
    );

    srmq_ram #(.WIDTH(2 * PW), .DEPTH(MAX_ELEMENTS + 1)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    assign o_result.valid                  = r_out_valid;
    assign o_result.positive_min           = r_out.positive_min;
    assign o_result.positive_max           = r_out.positive_max;
    assign o_result.negative_min_magnitude = r_out.negative_min_magnitude;
    assign o_result.negative_max_magnitude = r_out.negative_max_magnitude;
    assign o_result.nonnegative_count      = r_out.nonnegative_count;
    assign o_result.nonpositive_count      = r_out.nonpositive_count;
endmodule
`default_nettype wire

// ===== rtl/srmq_checker.sv =====
// port-level checks for the signed range min/max query block, bound to the top
`default_nettype none
`include "signed_range_min_max_query_assert.svh"
module srmq_checker
    import srmq_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_in_kind,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready
);
    // a waiting result word stays until taken
    `SRMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // a query keeps the input closed while its reads run
    `SRMQ_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n,
        i_in_valid && i_in_ready && i_in_kind == KIND_QUERY, !i_in_ready)
    // a build keeps the input closed
    `SRMQ_ASSERT_NEXT(a_build_busy, i_clk, i_rst_n,
        i_in_valid && i_in_ready && i_in_kind == KIND_BUILD, !i_in_ready)
    // a new result only appears after a busy cycle
    `SRMQ_ASSERT_NOW(a_res_origin, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))
endmodule

bind signed_range_min_max_query srmq_checker u_srmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_kind   (i_item.kind),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the signed range min/max query block
`default_nettype none
module testbench;
    import srmq_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         N_MAX      = MAX_ELEMENTS_DEF;
    localparam int         LEVELS     = TABLE_LEVELS_DEF;

    // mirrors the block's tables and checks each query answer in order
    class range_scoreboard;
        int            pmin_t[LEVELS][N_MAX];
        int            pmax_t[LEVELS][N_MAX];
        int            nmin_t[LEVELS][N_MAX];
        int            nmax_t[LEVELS][N_MAX];
        int            nonneg_pfx[N_MAX + 1];
        int            nonpos_pfx[N_MAX + 1];
        logic [10:0]   length_reg = LENGTH_RESET;
        t_result       answers[$];
        int            failures = 0;

        function int used_length();
            int n;
            n = length_reg;
            if (n < 1) n = 1;
            if (n > N_MAX) n = N_MAX;
            return n;
        endfunction

        function void load(int pos, logic signed [31:0] v);
            longint mag;
            int     s;
            if (pos < 1 || pos > N_MAX) return;
            s = pos - 1;
            if (v == 0) begin
                pmin_t[0][s] = 0; pmax_t[0][s] = 0; nmin_t[0][s] = 0; nmax_t[0][s] = 0;
                nonneg_pfx[pos] = 1; nonpos_pfx[pos] = 1;
            end else if (v > 0) begin
                pmin_t[0][s] = v; pmax_t[0][s] = v;
                nmin_t[0][s] = FULL_SCALE; nmax_t[0][s] = -1;
                nonneg_pfx[pos] = 1; nonpos_pfx[pos] = 0;
            end else begin
                mag = -longint'(v);
                if (mag > 64'd2147483647) mag = 64'd2147483647;
                pmin_t[0][s] = FULL_SCALE; pmax_t[0][s] = -1;
                nmin_t[0][s] = int'(mag); nmax_t[0][s] = int'(mag);
                nonneg_pfx[pos] = 0; nonpos_pfx[pos] = 1;
            end
        endfunction

        function void build();
            int n;
            int half;
            int a;
            int b;
            n = used_length();
            for (int lv = 1; lv < LEVELS && (1 << lv) <= n; lv++) begin
                half = 1 << (lv - 1);
                for (int j = 0; j + (1 << lv) <= n; j++) begin
                    a = j;
                    b = j + half;
                    pmin_t[lv][j] = pmin_t[lv-1][a] < pmin_t[lv-1][b] ?
                                    pmin_t[lv-1][a] : pmin_t[lv-1][b];
                    pmax_t[lv][j] = pmax_t[lv-1][a] > pmax_t[lv-1][b] ?
                                    pmax_t[lv-1][a] : pmax_t[lv-1][b];
                    nmin_t[lv][j] = nmin_t[lv-1][a] < nmin_t[lv-1][b] ?
                                    nmin_t[lv-1][a] : nmin_t[lv-1][b];
                    nmax_t[lv][j] = nmax_t[lv-1][a] > nmax_t[lv-1][b] ?
                                    nmax_t[lv-1][a] : nmax_t[lv-1][b];
                end
            end
            nonneg_pfx[0] = 0;
            nonpos_pfx[0] = 0;
            for (int i = 1; i <= n; i++) begin
                nonneg_pfx[i] = (nonneg_pfx[i] + nonneg_pfx[i-1]) & 32'h7FFF_FFFF;
                nonpos_pfx[i] = (nonpos_pfx[i] + nonpos_pfx[i-1]) & 32'h7FFF_FFFF;
            end
        endfunction

        function t_result query(int lo, int hi);
            t_result r;
            int n;
            int u;
            int a;
            int b;
            int pmin, pmax, nmin, nmax, cnn, cnp;
            n = used_length();
            pmin = FULL_SCALE; pmax = -1; nmin = FULL_SCALE; nmax = -1; cnn = 0; cnp = 0;
            if (lo < 1) lo = 1;
            if (hi > n) hi = n;
            if (lo <= hi) begin
                u = 0;
                while ((2 << u) <= hi - lo + 1) u++;
                if (u > LEVELS - 1) u = LEVELS - 1;
                a = lo - 1;
                b = hi - (1 << u);
                pmin = pmin_t[u][a] < pmin_t[u][b] ? pmin_t[u][a] : pmin_t[u][b];
                pmax = pmax_t[u][a] > pmax_t[u][b] ? pmax_t[u][a] : pmax_t[u][b];
                nmin = nmin_t[u][a] < nmin_t[u][b] ? nmin_t[u][a] : nmin_t[u][b];
                nmax = nmax_t[u][a] > nmax_t[u][b] ? nmax_t[u][a] : nmax_t[u][b];
                cnn = nonneg_pfx[hi] - nonneg_pfx[lo-1];
                cnp = nonpos_pfx[hi] - nonpos_pfx[lo-1];
            end
            r.positive_min           = pmin[30:0];
            r.positive_max           = pmax;
            r.negative_min_magnitude = nmin[30:0];
            r.negative_max_magnitude = nmax;
            r.nonnegative_count      = cnn[10:0];
            r.nonpositive_count      = cnp[10:0];
            return r;
        endfunction

        function void note_item(logic [1:0] kind, logic [10:0] pos, logic signed [31:0] v,
                                logic [10:0] lo, logic [10:0] hi);
            case (kind)
                KIND_LOAD:  load(pos, v);
                KIND_BUILD: build();
                KIND_QUERY: answers.push_back(query(lo, hi));
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (answers.size() == 0) begin
                $error("unexpected result word");
                failures++;
                return;
            end
            exp_r = answers.pop_front();
            if (got.positive_min !== exp_r.positive_min) begin
                $error("positive_min exp %0d got %0d", exp_r.positive_min, got.positive_min);
                failures++;
            end
            if (got.positive_max !== exp_r.positive_max) begin
                $error("positive_max exp %0d got %0d", exp_r.positive_max, got.positive_max);
                failures++;
            end
            if (got.negative_min_magnitude !== exp_r.negative_min_magnitude) begin
                $error("negative_min_magnitude exp %0d got %0d",
                       exp_r.negative_min_magnitude, got.negative_min_magnitude);
                failures++;
            end
            if (got.negative_max_magnitude !== exp_r.negative_max_magnitude) begin
                $error("negative_max_magnitude exp %0d got %0d",
                       exp_r.negative_max_magnitude, got.negative_max_magnitude);
                failures++;
            end
            if (got.nonnegative_count !== exp_r.nonnegative_count) begin
                $error("nonnegative_count exp %0d got %0d",
                       exp_r.nonnegative_count, got.nonnegative_count);
                failures++;
            end
            if (got.nonpositive_count !== exp_r.nonpositive_count) begin
                $error("nonpositive_count exp %0d got %0d",
                       exp_r.nonpositive_count, got.nonpositive_count);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srmq_item_if   item_ch();
    srmq_cfg_if    cfg_ch();
    srmq_result_if result_ch();

    signed_range_min_max_query dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    range_scoreboard board = new();
    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;
    int word_count = 0;

    always #4 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("signed_range_min_max_query regression: fail");
        $finish;
    end

    function int draw_gap();
        return idle_on ? $urandom_range(0, 15) : 0;
    endfunction

    function logic signed [31:0] draw_value();
        case ($urandom_range(0, 9))
            0: return 32'sd0;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            4, 5: return $signed(32'($urandom_range(0, 20))) - 32'sd10;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(result_ch.valid && result_ch.ready)) @(posedge i_clk);
            board.check_result('{result_ch.positive_min, result_ch.positive_max,
                                 result_ch.negative_min_magnitude,
                                 result_ch.negative_max_magnitude,
                                 result_ch.nonnegative_count, result_ch.nonpositive_count});
        end
    end

    task automatic send_item(logic [1:0] kind, logic [10:0] pos, logic signed [31:0] v,
                             logic [10:0] lo, logic [10:0] hi);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.kind     <= kind;
        item_ch.position <= pos;
        item_ch.value    <= v;
        item_ch.first    <= lo;
        item_ch.last     <= hi;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        board.note_item(kind, pos, v, lo, hi);
        if (kind != KIND_SPARE) word_count++;
    endtask

    task automatic load_word(int pos, logic signed [31:0] v);
        send_item(KIND_LOAD, pos[10:0], v, 11'($urandom), 11'($urandom));
    endtask

    task automatic query_word(int lo, int hi);
        send_item(KIND_QUERY, 11'($urandom), $urandom, lo[10:0], hi[10:0]);
    endtask

    task automatic build_word();
        send_item(KIND_BUILD, 11'($urandom), $urandom, 11'($urandom), 11'($urandom));
    endtask

    // only between phases: drain, let any build finish, then write
    task automatic write_length(logic [10:0] len);
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.array_length <= len;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.length_reg = len;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_query(int n);
        int lo;
        int hi;
        if ($urandom_range(0, 4) == 0) begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
        end else begin
            lo = $urandom_range(1, n);
            hi = $urandom_range(lo, n);
        end
        query_word(lo, hi);
    endtask

    task automatic run_phase(logic [10:0] len, bit with_hold);
        int n;
        n = len < 1 ? 1 : (len > N_MAX ? N_MAX : len);
        write_length(len);
        idle_on = $urandom_range(0, 3) != 0;
        for (int p = 1; p <= n; p++) begin
            if ($urandom_range(0, 15) == 0) begin
                // words the block drops
                if ($urandom_range(0, 1))
                    send_item(KIND_SPARE, 11'($urandom), $urandom, 11'($urandom),
                              11'($urandom));
                else
                    load_word($urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047),
                              draw_value());
            end
            load_word(p, draw_value());
        end
        build_word();
        if (with_hold) hold_req = 1'b1;
        repeat ($urandom_range(5, 25)) random_query(n);
        if ($urandom_range(0, 3) == 0) begin
            // reload some words, query stale tables, maybe rebuild
            repeat ($urandom_range(1, 4)) load_word($urandom_range(1, n), draw_value());
            if ($urandom_range(0, 1)) build_word();
            repeat ($urandom_range(2, 8)) random_query(n);
        end
    endtask

    initial begin
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_LOAD;
        item_ch.position = '0;
        item_ch.value = '0;
        item_ch.first = '0;
        item_ch.last = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.array_length = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, ignored words, clipped and empty ranges
        write_length(11'd6);
        load_word(1, 32'sd0);
        load_word(2, 32'sh7FFF_FFFF);
        load_word(3, -32'sh7FFF_FFFF);
        load_word(4, 32'sh8000_0000);
        load_word(5, 32'sd1);
        load_word(6, -32'sd1);
        load_word(0, 32'sd5);
        load_word(1025, 32'sd5);
        load_word(2047, -32'sd5);
        send_item(KIND_SPARE, 11'h7FF, 32'shFFFF_FFFF, 11'h7FF, 11'h7FF);
        build_word();
        query_word(0, 2047);
        query_word(1, 1);
        query_word(3, 2);
        query_word(2, 5);
        query_word(6, 6);
        query_word(5, 2047);
        query_word(2047, 1024);
        write_length(11'd0);
        load_word(1, -32'sd7);
        build_word();
        query_word(0, 0);
        query_word(1, 1);
        query_word(2, 5);

        run_phase(11'd1, 1'b0);
        run_phase(11'd600, 1'b1);
        while (word_count < 820) run_phase(11'($urandom_range(2, 40)), 1'b0);

        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.failures == 0)
            $display("signed_range_min_max_query regression: pass");
        else
            $display("signed_range_min_max_query regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/srmq_pkg.sv
rtl/srmq_ifs.sv
rtl/srmq_ram.sv
rtl/signed_range_min_max_query.sv
rtl/srmq_checker.sv
test/testbench.sv
